FILE: design/b64_pkg.sv
// Package for the base64 stream codec: payload and job types, queue sizing,
// alphabet and character classification functions. No dependencies.
package b64_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [5:0] SEXTET_MSK = 6'h3F;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic REG_DIRECTION = 1'b0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       bad_char;
    } t_out;

    typedef struct packed {
        logic        dir;
        logic [23:0] bits;
        logic [2:0]  count;
        logic [2:0]  nchars;
        logic        last;
        logic        bad;
    } t_job;

    function automatic logic [7:0] char_of(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'd65 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'd97 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'd48 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'd43;
        end else begin
            c = 8'd47;
        end
        return c;
    endfunction

    // bit 6 flags a character outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'd65 && c <= 8'd90) begin
            r = {1'b0, 6'(c - 8'd65)};
        end else if (c >= 8'd97 && c <= 8'd122) begin
            r = {1'b0, 6'(c - 8'd97 + 8'd26)};
        end else if (c >= 8'd48 && c <= 8'd57) begin
            r = {1'b0, 6'(c - 8'd48 + 8'd52)};
        end else if (c == 8'd43) begin
            r = {1'b0, 6'd62};
        end else if (c == 8'd47) begin
            r = {1'b0, 6'd63};
        end else begin
            r = {1'b1, 6'd0};
        end
        return r;
    endfunction

endpackage

FILE: design/b64_front.sv
// Front end of the base64 codec: takes input transfers, gathers groups and
// pushes one job per group that yields output. Depends on b64_pkg.
module b64_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_dir,
    input  logic             i_clear,
    input  logic             i_valid,
    input  b64_pkg::t_in     i_data,
    output logic             o_ready,
    input  logic             i_q_full,
    output logic             o_push,
    output b64_pkg::t_job    o_job
);

    logic [23:0] r_bits, n_bits;
    logic [1:0]  r_fill, n_fill;
    logic [1:0]  r_pad,  n_pad;
    logic        r_err,  n_err;

    logic        accept;
    logic [23:0] gb;
    logic [2:0]  n_cnt;
    logic        is_pad;
    logic [6:0]  sx;
    logic [5:0]  v;
    logic [1:0]  pad_next;
    logic        err_next;
    logic [2:0]  nbytes;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_bits   = r_bits;
        n_fill   = r_fill;
        n_pad    = r_pad;
        n_err    = r_err;
        o_push   = 1'b0;
        o_job    = '0;
        o_job.dir  = i_dir;
        o_job.last = i_data.in_last;
        gb       = '0;
        n_cnt    = {1'b0, r_fill} + 3'd1;
        is_pad   = (i_data.in_byte == b64_pkg::PAD_CHAR);
        sx       = b64_pkg::sextet_of(i_data.in_byte);
        v        = is_pad ? 6'd0 : (sx[5:0] & b64_pkg::SEXTET_MSK);
        pad_next = (is_pad && r_pad != 2'd3) ? r_pad + 2'd1 : r_pad;
        err_next = r_err | (!is_pad & sx[6]);
        nbytes   = (pad_next == 2'd3) ? 3'd0 : 3'd3 - {1'b0, pad_next};
        if (i_clear) begin
            n_bits = '0;
            n_fill = '0;
            n_pad  = '0;
            n_err  = 1'b0;
        end else if (accept) begin
            if (i_dir == b64_pkg::DIR_ENCODE) begin
                gb = {r_bits[15:0], i_data.in_byte};
                if (n_cnt < 3'd3 && !i_data.in_last) begin
                    n_bits = gb;
                    n_fill = n_cnt[1:0];
                end else begin
                    case (n_cnt)
                        3'd1:    o_job.bits = {gb[7:0], 16'd0};
                        3'd2:    o_job.bits = {gb[15:0], 8'd0};
                        default: o_job.bits = gb;
                    endcase
                    o_job.count  = 3'd4;
                    o_job.nchars = n_cnt + 3'd1;
                    o_push = 1'b1;
                    n_bits = '0;
                    n_fill = '0;
                    n_pad  = '0;
                    n_err  = 1'b0;
                end
            end else begin
                gb = {r_bits[17:0], v};
                if (r_fill != 2'd3) begin
                    if (i_data.in_last) begin
                        n_bits = '0;
                        n_fill = '0;
                        n_pad  = '0;
                        n_err  = 1'b0;
                    end else begin
                        n_bits = gb;
                        n_fill = r_fill + 2'd1;
                        n_pad  = pad_next;
                        n_err  = err_next;
                    end
                end else begin
                    o_job.bits   = gb;
                    o_job.count  = nbytes;
                    o_job.nchars = 3'd0;
                    o_job.bad    = err_next;
                    o_push = (nbytes != 3'd0);
                    n_bits = '0;
                    n_fill = '0;
                    n_pad  = '0;
                    n_err  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_fill <= '0;
            r_pad  <= '0;
            r_err  <= 1'b0;
        end else begin
            r_bits <= n_bits;
            r_fill <= n_fill;
            r_pad  <= n_pad;
            r_err  <= n_err;
        end
    end

endmodule

FILE: design/b64_queue.sv
// Job queue between the front and back ends of the base64 codec.
// Small register FIFO sized by b64_pkg::QDEPTH. Depends on b64_pkg.
module b64_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64_pkg::t_job  i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output b64_pkg::t_job  o_job
);

    b64_pkg::t_job r_mem [b64_pkg::QDEPTH];
    logic [b64_pkg::QPTR_W-1:0] r_wr, n_wr;
    logic [b64_pkg::QPTR_W-1:0] r_rd, n_rd;
    logic [b64_pkg::QCNT_W-1:0] r_cnt, n_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == b64_pkg::QCNT_W'(b64_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: design/b64_back.sv
// Back end of the base64 codec, depends on b64_pkg: takes jobs from the queue
// and emits one char or byte per cycle via an output register unless stalled.
module b64_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  b64_pkg::t_job  i_job,
    output logic           o_pop,
    output logic           o_valid,
    output b64_pkg::t_out  o_data,
    input  logic           i_ready
);

    b64_pkg::t_job r_job, n_job;
    logic          r_busy, n_busy;
    logic [1:0]    r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    b64_pkg::t_out r_out, n_out;

    logic          load;
    logic          final_item;
    logic [5:0]    sext;
    b64_pkg::t_out item;

    assign load       = !r_out_valid || i_ready;
    assign final_item = ({1'b0, r_idx} + 3'd1 == r_job.count);
    assign o_pop      = i_q_valid && (!r_busy || (load && final_item));
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    always_comb begin
        case (r_idx)
            2'd0:    sext = r_job.bits[23:18];
            2'd1:    sext = r_job.bits[17:12];
            2'd2:    sext = r_job.bits[11:6];
            default: sext = r_job.bits[5:0];
        endcase
        item.out_last = final_item && r_job.last;
        item.bad_char = r_job.bad;
        if (r_job.dir == b64_pkg::DIR_ENCODE) begin
            item.out_byte = ({1'b0, r_idx} < r_job.nchars) ?
                            b64_pkg::char_of(sext) : b64_pkg::PAD_CHAR;
        end else begin
            case (r_idx)
                2'd0:    item.out_byte = r_job.bits[23:16];
                2'd1:    item.out_byte = r_job.bits[15:8];
                default: item.out_byte = r_job.bits[7:0];
            endcase
        end
    end

    always_comb begin
        n_job       = r_job;
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (load) begin
            n_out_valid = r_busy;
            if (r_busy) begin
                n_out = item;
                if (final_item) begin
                    n_busy = 1'b0;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
        end
        if (o_pop) begin
            n_job  = i_job;
            n_busy = 1'b1;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: design/base64_stream_codec.sv
// The first result of a group passes through the job queue, the back end's job
// register and its output register; results then follow one per cycle unless
// i_ready stalls. One input transfer is taken per cycle while the job queue
// has room; the back end emits one result per cycle while i_ready allows.
// Reset: synchronous, active low; clears direction (encode), group state,
// queue and output valid flag. Top level; depends on b64_pkg and submodules.
module base64_stream_codec (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  b64_pkg::t_in  i_data,
    output logic          o_ready,
    output logic          o_valid,
    output b64_pkg::t_out o_data,
    input  logic          i_ready,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic          r_dir, n_dir;
    logic          wr_dir;
    logic          push, pop, q_full, q_valid;
    b64_pkg::t_job f_job, q_job;

    assign pready = 1'b1;
    assign wr_dir = psel && penable && pwrite && pready
                    && (paddr[2] == b64_pkg::REG_DIRECTION);
    assign n_dir  = wr_dir ? pwdata[0] : r_dir;
    assign prdata = (paddr[2] == b64_pkg::REG_DIRECTION) ? {31'd0, r_dir} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= b64_pkg::DIR_ENCODE;
        end else begin
            r_dir <= n_dir;
        end
    end

    b64_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dir    (r_dir),
        .i_clear  (wr_dir),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .o_ready  (o_ready),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (f_job)
    );

    b64_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    b64_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (q_job),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_ready   (i_ready)
    );

endmodule
